// ===== hdl/sitad_pkg.sv =====
`timescale 1ns / 1ps
package sitad_pkg;
	localparam int         VALUE_BITS = 32;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_ALPHA = 7'h41;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic       OP_DEC     = 1'b0;
	localparam logic       OP_HEX     = 1'b1;
	localparam int         DIGIT_MAX  = 20;
	localparam int         CNT_W      = 5;

	// Map a digit value of 0 to 15 to its ASCII code.
	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] r;
		if (d > 4'd9) begin
			r = CHAR_ALPHA + {3'd0, d} - 7'd10;
		end else begin
			r = CHAR_ZERO + {3'd0, d};
		end
		return r;
	endfunction
endpackage

// ===== hdl/sitad_in_if.sv =====
`timescale 1ns / 1ps
interface sitad_in_if;
	import sitad_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  opcode;
	modport source (output valid, output value, output opcode, input ready);
	modport sink (input valid, input value, input opcode, output ready);
endinterface

// ===== hdl/sitad_out_if.sv =====
`timescale 1ns / 1ps
interface sitad_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last;
	modport source (output valid, output char_code, output last, input ready);
	modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== hdl/signed_int_to_ascii_digits_core.sv =====
`timescale 1ns / 1ps
// Converts a signed integer to ASCII decimal or upper-case hex, most significant
// character first, with a leading '-' for negatives and last marking the final
// character. Stage 1 forms the magnitude, stage 2 splits it into digits and
// stage 3 sends one character per cycle while the receiver is ready. A number
// takes 1 to 11 characters at 32 bits. Hex digits are split in the cycle that
// loads stage 2. Decimal digits are found most significant first, one per
// cycle, by comparing the remainder against the nine multiples of the current
// power of ten, so stage 2 works on a decimal number while stage 3 may still be
// sending the previous number. With an idle pipeline the first character is
// presented once the number has passed the stage 1, stage 2 and stage 3
// registers, and for decimal once stage 2 has also found every digit.
module signed_int_to_ascii_digits_core (
	input logic clk,
	input logic arst_n,
	sitad_in_if.sink  in_ch,
	sitad_out_if.source out_ch
);
	import sitad_pkg::*;

	// Decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
	localparam int ND = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int NH = (VALUE_BITS + 3) / 4;

	// Stage 1: magnitude.
	logic                  v_s1, neg_s1, hex_s1;
	logic [VALUE_BITS-1:0] mag_s1;
	// Stage 2: digit extraction.
	logic                  v_s2, neg_s2, hex_s2, busy_s2;
	logic [VALUE_BITS-1:0] rem_s2;
	logic [3:0]            dig_s2 [DIGIT_MAX];
	logic [CNT_W-1:0]      nd_s2, pos_s2;
	// Stage 3: output sequencer.
	logic                  v_s3, neg_s3, sign_q;
	logic [3:0]            dig_s3 [DIGIT_MAX];
	logic [CNT_W-1:0]      idx_q;

	logic adv3, ld3, ld2, ld1, done2;
	logic [VALUE_BITS-1:0] vin;
	logic [VALUE_BITS+3:0] pmul [DIGIT_MAX][10];
	logic [CNT_W-1:0]      top_ld;
	logic [3:0]            dsel;
	logic [VALUE_BITS+3:0] dsub;

	// m times ten to the power k, evaluated on constants only.
	function automatic logic [VALUE_BITS+3:0] pow_mul(input int k, input int m);
		logic [VALUE_BITS+3:0] p, r;
		p = {{(VALUE_BITS + 3){1'b0}}, 1'b1};
		for (int i = 0; i < k; i++) p = (p << 3) + (p << 1);
		r = '0;
		for (int j = 0; j < m; j++) r = r + p;
		return r;
	endfunction

	assign vin = in_ch.value[VALUE_BITS-1:0];

	// Constant table of digit multiples of each power of ten; unused powers never match.
	always_comb begin
		for (int k = 0; k < DIGIT_MAX; k++) begin
			for (int m = 0; m < 10; m++) begin
				pmul[k][m] = (k < ND) ? pow_mul(k, m) : '1;
			end
		end
	end

	// Index of the most significant digit of the magnitude waiting in stage 1.
	always_comb begin
		top_ld = '0;
		if (hex_s1) begin
			for (int i = 1; i < NH; i++) begin
				if ((mag_s1 >> (4 * i)) != '0) top_ld = CNT_W'(i);
			end
		end else begin
			for (int i = 1; i < DIGIT_MAX; i++) begin
				if ({4'd0, mag_s1} >= pmul[i][1]) top_ld = CNT_W'(i);
			end
		end
	end

	// Current decimal digit: the largest multiple of the current power that fits.
	always_comb begin
		dsel = 4'd0;
		dsub = '0;
		for (int m = 1; m < 10; m++) begin
			if ({4'd0, rem_s2} >= pmul[pos_s2][m]) begin
				dsel = 4'(m);
				dsub = pmul[pos_s2][m];
			end
		end
	end

	assign done2 = v_s2 && (hex_s2 || !busy_s2);
	assign adv3  = v_s3 && out_ch.ready && (sign_q ? 1'b0 : idx_q == '0);
	assign ld3   = done2 && (!v_s3 || adv3);
	assign ld2   = v_s1 && (!v_s2 || ld3);
	assign ld1   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !v_s1 || ld2;

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ld1) begin
			neg_s1 <= vin[VALUE_BITS-1];
			hex_s1 <= in_ch.opcode == OP_HEX;
			mag_s1 <= vin[VALUE_BITS-1] ? (~vin + 1'b1) : vin;
		end
	end

	// Stage 2: hex splits at once, decimal finds one digit per cycle from the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			busy_s2 <= 1'b0;
		end else begin
			if (ld2) begin
				v_s2    <= 1'b1;
				busy_s2 <= !hex_s1;
			end else if (ld3) begin
				v_s2    <= 1'b0;
				busy_s2 <= 1'b0;
			end else if (busy_s2 && pos_s2 == '0) begin
				busy_s2 <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (ld2) begin
			neg_s2 <= neg_s1;
			hex_s2 <= hex_s1;
			rem_s2 <= mag_s1;
			nd_s2  <= top_ld;
			pos_s2 <= top_ld;
			for (int i = 0; i < DIGIT_MAX; i++) begin
				dig_s2[i] <= (i < NH) ? 4'(mag_s1 >> (4 * i)) : 4'd0;
			end
		end else if (busy_s2) begin
			dig_s2[pos_s2] <= dsel;
			rem_s2         <= rem_s2 - dsub[VALUE_BITS-1:0];
			pos_s2         <= pos_s2 - 1'b1;
		end
	end

	// Stage 3: emit sign, then digits from the top index down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3   <= 1'b0;
			sign_q <= 1'b0;
			idx_q  <= '0;
		end else if (ld3) begin
			v_s3   <= 1'b1;
			sign_q <= neg_s2;
			idx_q  <= nd_s2;
		end else if (adv3) begin
			v_s3 <= 1'b0;
		end else if (v_s3 && out_ch.ready) begin
			if (sign_q) sign_q <= 1'b0;
			else idx_q <= idx_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ld3) begin
			neg_s3 <= neg_s2;
			dig_s3 <= dig_s2;
		end
	end

	assign out_ch.valid     = v_s3;
	assign out_ch.char_code = sign_q ? CHAR_MINUS : digit_char(dig_s3[idx_q]);
	assign out_ch.last      = !sign_q && idx_q == '0;

`ifndef SYNTHESIS
	a_last_no_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && sign_q |-> !out_ch.last) else $error("sign marked last");
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && sign_q |-> neg_s3) else $error("sign without negative");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> idx_q < CNT_W'(ND + 1)) else $error("digit index out of range");
`endif
endmodule

// ===== tb/sv/signed_int_to_ascii_digits_core_test.sv =====
`timescale 1ns / 1ps
module signed_int_to_ascii_digits_core_test;
	import sitad_pkg::*;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} char_t;

	logic clk;
	logic arst_n;
	int   error_count;
	char_t expected_chars[$];
	int   burst_left;
	bit   stall_enable;

	sitad_in_if  in_ch();
	sitad_out_if out_ch();

	signed_int_to_ascii_digits_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Compute the characters of one number and queue them.
	task automatic predict_chars(input logic [31:0] value, input logic opcode);
		logic [31:0] mag;
		logic [3:0]  digit;
		logic [6:0]  digits[$];
		bit          neg;
		neg = value[31];
		mag = neg ? (~value + 32'd1) : value;
		do begin
			if (opcode == OP_HEX) begin
				digit = mag[3:0];
				mag = mag >> 4;
			end else begin
				digit = 4'(mag % 32'd10);
				mag = mag / 32'd10;
			end
			digits.push_front(digit > 4'd9 ? CHAR_ALPHA + 7'(digit) - 7'd10
				: CHAR_ZERO + 7'(digit));
		end while (mag != 0);
		if (neg) begin
			expected_chars.push_back('{CHAR_MINUS, 1'b0});
		end
		foreach (digits[i]) begin
			expected_chars.push_back('{digits[i], i == digits.size() - 1});
		end
	endtask

	// Send one number, with bursts and random gaps between them.
	task automatic send_number(input logic [31:0] value, input logic opcode);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_ch.valid  <= 1'b1;
		in_ch.value  <= value;
		in_ch.opcode <= opcode;
		predict_chars(value, opcode);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain_outputs();
		in_ch.valid <= 1'b0;
		while (expected_chars.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	// Receiver stall pattern: stretches of free flow and random stalls.
	always @(posedge clk) begin
		if (!stall_enable) begin
			out_ch.ready <= 1'b1;
		end else begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		stall_enable = 1'b0;
		forever begin
			repeat ($urandom_range(50, 300)) @(posedge clk);
			stall_enable = ~stall_enable;
		end
	end

	// Check each transfer on the output against the oldest expectation.
	always @(posedge clk) begin
		char_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_chars.size() == 0) begin
				$error("unexpected character %h", out_ch.char_code);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (out_ch.char_code !== want.char_code) begin
					$error("char_code expected %h actual %h", want.char_code,
						out_ch.char_code);
					error_count++;
				end
				if (out_ch.last !== want.last) begin
					$error("last expected %b actual %b", want.last, out_ch.last);
					error_count++;
				end
			end
		end
	end

	// Extremes of the value field in both radixes, plus two more decimal values.
	task automatic test_extremes();
		logic [31:0] vals[9] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0001, 32'd9, 32'd10, 32'hFFFF_FF01};
		foreach (vals[i]) begin
			send_number(vals[i], OP_DEC);
			send_number(vals[i], OP_HEX);
		end
		send_number(32'hFFFF_FFF6, OP_DEC);
		send_number(32'hC465_3600, OP_DEC);
	endtask

	// Random values with varied magnitudes, both radixes.
	task automatic test_random(input int count);
		logic [31:0] v;
		for (int i = 0; i < count; i++) begin
			v = $urandom();
			if ($urandom_range(0, 2) == 0) begin
				v = $signed(v) >>> $urandom_range(0, 31);
			end
			send_number(v, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		error_count  = 0;
		burst_left   = 0;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.value  = '0;
		in_ch.opcode = OP_DEC;
		out_ch.ready = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random(150);
		// Hold off until the output has caught up, then continue.
		drain_outputs();
		test_random(180);
		drain_outputs();
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Timeout.
	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/sitad_pkg.sv
hdl/sitad_in_if.sv
hdl/sitad_out_if.sv
hdl/signed_int_to_ascii_digits_core.sv
tb/sv/signed_int_to_ascii_digits_core_test.sv
